### sv/ttb_pkg.sv
// ttb_pkg: shared types and constants for the tangent/bitangent block.
// No dependencies.
package ttb_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned NRM_W  = 16;
	localparam int unsigned PROD_W = 66;
	localparam int unsigned NUM_W  = 65;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic signed [NRM_W-1:0]  nrm_t;

	// Shared divider handshake.
	typedef struct packed {
		logic        start;
		logic        num_neg;
		logic        den_neg;
		logic [NUM_W-1:0] num;
		logic [NUM_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		word_t       quo;
	} div_rsp_t;

	function automatic word_t sat32(input logic signed [WORD_W:0] x);
		logic signed [WORD_W:0] hi;
		logic signed [WORD_W:0] lo;
		hi = (WORD_W+1)'(33'sh0_7FFF_FFFF);
		lo = -(WORD_W+1)'(33'sh0_8000_0000);
		if (x > hi)
			sat32 = word_t'(hi);
		else if (x < lo)
			sat32 = word_t'(lo);
		else
			sat32 = word_t'(x);
	endfunction

endpackage

### sv/ttb_div.sv
// ttb_div: restoring divider, one quotient bit per cycle.
// Computes sat32(n * 2^FRAC_BITS / d) toward zero. Depends on ttb_pkg.
module ttb_div import ttb_pkg::*; #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	localparam int unsigned QB  = NUM_W + FRAC_BITS;
	localparam int unsigned CW  = $clog2(QB + 1);

	logic            busy_q;
	logic [CW-1:0]   cnt_q;
	logic [QB-1:0]   sh_q;
	logic [NUM_W-1:0] rem_q;
	logic [NUM_W-1:0] den_q;
	logic            neg_q;
	logic            done_q;
	logic [NUM_W:0]  trial;
	logic [NUM_W:0]  rem_n;
	logic [QB-1:0]   q_n;
	logic [QB-1:0]   mag;
	word_t           res;

	always_comb begin
		trial = {rem_q, sh_q[QB-1]};
		if (trial >= {1'b0, den_q}) begin
			rem_n = trial - {1'b0, den_q};
			q_n   = {sh_q[QB-2:0], 1'b1};
		end else begin
			rem_n = trial;
			q_n   = {sh_q[QB-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			sh_q  <= {req.num, FRAC_BITS'(0)};
			rem_q <= '0;
			den_q <= req.den;
			neg_q <= req.num_neg ^ req.den_neg;
		end else if (busy_q) begin
			sh_q  <= q_n;
			// remainder stays below the divisor, so it fits NUM_W bits
			rem_q <= rem_n[NUM_W-1:0];
		end
	end

	always_comb begin
		mag = sh_q;
		if (|mag[QB-1:WORD_W])
			res = neg_q ? word_t'(32'h8000_0000) : word_t'(32'h7FFF_FFFF);
		else if (neg_q)
			res = (mag[WORD_W-1:0] > 32'h8000_0000) ? word_t'(32'h8000_0000)
				: word_t'(-mag[WORD_W-1:0]);
		else
			res = mag[WORD_W-1] ? word_t'(32'h7FFF_FFFF) : word_t'(mag[WORD_W-1:0]);
	end

	assign rsp.done = done_q;
	assign rsp.quo  = res;

endmodule

### sv/triangle_tangent_bitangent.sv
// triangle_tangent_bitangent: top level, sequencer, shared multiplier, divider.
// Depends on ttb_pkg and ttb_div.
//
// Vertices come in as start/busy transactions, three per triangle; a
// transaction is accepted at a clock edge with start high and busy low. The
// first two vertices are stored. The third starts the sequencer: deltas, then
// D and the six numerators as pairs of products on one shared 33x33
// multiplier, then six divisions on one restoring divider (65+FRAC_BITS
// quotient bits), then per vertex a cross product and a dot product on the
// same multiplier and an output state. The third vertex keeps busy high for
// the whole sequence, whose length is set almost entirely by the divisions;
// with a zero UV determinant the divisions are skipped. The three results
// come out one after another, each marked by valid for one cycle; the last
// one is on the ports in the first cycle with busy low. The receiver cannot
// stall.
module triangle_tangent_bitangent import ttb_pkg::*; #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] tex_u,
	input  logic signed [31:0] tex_v,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic signed [15:0] normal_z,
	output logic        valid,
	output logic signed [31:0] tangent_x,
	output logic signed [31:0] tangent_y,
	output logic signed [31:0] tangent_z,
	output logic signed [31:0] bitangent_x,
	output logic signed [31:0] bitangent_y,
	output logic signed [31:0] bitangent_z,
	output logic        degenerate,
	output logic        last_of_triangle
);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_DELT = 8'b0000_0010,
		S_MUL  = 8'b0000_0100,
		S_DIVS = 8'b0000_1000,
		S_DIVW = 8'b0001_0000,
		S_CRS  = 8'b0010_0000,
		S_DOT  = 8'b0100_0000,
		S_OUT  = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic [1:0] slot_q;

	// Held vertices 0/1 and the third in index 2.
	word_t p_q [3][3];
	word_t t_q [3][2];
	nrm_t  n_q [3][3];

	word_t e1_q [3], e2_q [3];
	word_t du1_q, dv1_q, du2_q, dv2_q;

	logic signed [PROD_W-1:0] prod_q;   // registered multiplier result
	logic signed [PROD_W-1:0] acc_q;    // first product of a pair
	logic [NUM_W-1:0] dm_q;
	logic dneg_q, degen_q;
	logic [NUM_W-1:0] num_q [6];
	logic             nneg_q[6];
	word_t vec_q [6];                   // tan x,y,z then bit x,y,z

	logic [3:0] step_q;                 // multiply step / division index
	logic [1:0] vtx_q;
	logic signed [49:0] c_q [3];
	logic signed [83:0] dot_q;

	// Shared multiplier operands.
	logic signed [32:0] ma, mb;
	logic signed [65:0] mprod;
	assign mprod = ma * mb;

	div_req_t dreq;
	div_rsp_t drsp;
	ttb_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp)
	);

	// Dot product: c (50b) * bit (32b), split into a signed high and an
	// unsigned low 25-bit half, both run on the shared multiplier.
	logic [1:0] dk;
	logic [2:0] bk;
	logic signed [32:0] dlo_a;
	logic signed [32:0] dhi_a;
	assign dk    = (step_q[2:1] == 2'd3) ? 2'd0 : step_q[2:1];
	assign bk    = 3'd3 + 3'(dk);
	assign dlo_a = 33'({1'b0, c_q[dk][24:0]});
	assign dhi_a = 33'($signed(c_q[dk][49:25]));

	// Multiply schedule: pairs (a,b) whose difference is a numerator.
	// step 0,1: D ; 2..7: tangent numerators ; 8..13 bitangent; then cross/dot.
	always_comb begin
		ma = '0; mb = '0;
		if (state_q == S_MUL) begin
			case (step_q)
				4'd0:  begin ma = 33'(du1_q); mb = 33'(dv2_q); end
				4'd1:  begin ma = 33'(dv1_q); mb = 33'(du2_q); end
				4'd2:  begin ma = 33'(e1_q[0]); mb = 33'(dv2_q); end
				4'd3:  begin ma = 33'(e2_q[0]); mb = 33'(dv1_q); end
				4'd4:  begin ma = 33'(e1_q[1]); mb = 33'(dv2_q); end
				4'd5:  begin ma = 33'(e2_q[1]); mb = 33'(dv1_q); end
				4'd6:  begin ma = 33'(e1_q[2]); mb = 33'(dv2_q); end
				4'd7:  begin ma = 33'(e2_q[2]); mb = 33'(dv1_q); end
				4'd8:  begin ma = 33'(e2_q[0]); mb = 33'(du1_q); end
				4'd9:  begin ma = 33'(e1_q[0]); mb = 33'(du2_q); end
				4'd10: begin ma = 33'(e2_q[1]); mb = 33'(du1_q); end
				4'd11: begin ma = 33'(e1_q[1]); mb = 33'(du2_q); end
				4'd12: begin ma = 33'(e2_q[2]); mb = 33'(du1_q); end
				4'd13: begin ma = 33'(e1_q[2]); mb = 33'(du2_q); end
				default: begin ma = '0; mb = '0; end
			endcase
		end else if (state_q == S_CRS) begin
			// c0 = ny*tz - nz*ty ; c1 = nz*tx - nx*tz ; c2 = nx*ty - ny*tx
			case (step_q)
				4'd0: begin ma = 33'(n_q[vtx_q][1]); mb = 33'(vec_q[2]); end
				4'd1: begin ma = 33'(n_q[vtx_q][2]); mb = 33'(vec_q[1]); end
				4'd2: begin ma = 33'(n_q[vtx_q][2]); mb = 33'(vec_q[0]); end
				4'd3: begin ma = 33'(n_q[vtx_q][0]); mb = 33'(vec_q[2]); end
				4'd4: begin ma = 33'(n_q[vtx_q][0]); mb = 33'(vec_q[1]); end
				4'd5: begin ma = 33'(n_q[vtx_q][1]); mb = 33'(vec_q[0]); end
				default: begin ma = '0; mb = '0; end
			endcase
		end else if (state_q == S_DOT) begin
			ma = step_q[0] ? dhi_a : dlo_a;
			mb = 33'(vec_q[bk]);
		end
	end

	word_t tsel [3];
	always_comb begin
		for (int k = 0; k < 3; k++)
			tsel[k] = (dot_q < 0)
				? ((vec_q[k] == word_t'(32'h8000_0000)) ? word_t'(32'h7FFF_FFFF) : -vec_q[k])
				: vec_q[k];
	end

	always_comb begin
		dreq.start   = (state_q == S_DIVS) && !degen_q;
		dreq.num     = num_q[step_q[2:0] > 3'd5 ? 3'd0 : step_q[2:0]];
		dreq.num_neg = nneg_q[step_q[2:0] > 3'd5 ? 3'd0 : step_q[2:0]];
		dreq.den     = dm_q;
		dreq.den_neg = dneg_q;
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			slot_q  <= '0;
			step_q  <= '0;
			vtx_q   <= '0;
			valid   <= 1'b0;
		end else begin
			valid <= 1'b0;
			case (state_q)
				S_IDLE: if (start) begin
					if (slot_q == 2'd2) begin
						slot_q  <= '0;
						state_q <= S_DELT;
					end else
						slot_q <= slot_q + 1'b1;
				end
				S_DELT: begin
					step_q  <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (step_q == 4'd13) begin
						step_q  <= '0;
						state_q <= S_DIVS;
					end else
						step_q <= step_q + 1'b1;
				end
				S_DIVS: begin
					if (degen_q) begin
						step_q  <= '0;
						vtx_q   <= '0;
						state_q <= S_CRS;
					end else
						state_q <= S_DIVW;
				end
				S_DIVW: if (drsp.done) begin
					if (step_q == 4'd5) begin
						step_q  <= '0;
						vtx_q   <= '0;
						state_q <= S_CRS;
					end else begin
						step_q  <= step_q + 1'b1;
						state_q <= S_DIVS;
					end
				end
				S_CRS: begin
					if (step_q == 4'd6) begin
						step_q  <= '0;
						state_q <= S_DOT;
					end else
						step_q <= step_q + 1'b1;
				end
				S_DOT: begin
					if (step_q == 4'd5)
						state_q <= S_OUT;
					else
						step_q <= step_q + 1'b1;
				end
				S_OUT: begin
					valid  <= 1'b1;
					step_q <= '0;
					if (vtx_q == 2'd2) begin
						state_q <= S_IDLE;
					end else begin
						vtx_q   <= vtx_q + 1'b1;
						state_q <= S_CRS;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			p_q[slot_q][0] <= pos_x; p_q[slot_q][1] <= pos_y; p_q[slot_q][2] <= pos_z;
			t_q[slot_q][0] <= tex_u; t_q[slot_q][1] <= tex_v;
			n_q[slot_q][0] <= normal_x; n_q[slot_q][1] <= normal_y;
			n_q[slot_q][2] <= normal_z;
		end
		if (state_q == S_DELT) begin
			for (int k = 0; k < 3; k++) begin
				e1_q[k] <= sat32(33'(p_q[1][k]) - 33'(p_q[0][k]));
				e2_q[k] <= sat32(33'(p_q[2][k]) - 33'(p_q[0][k]));
			end
			du1_q <= sat32(33'(t_q[1][0]) - 33'(t_q[0][0]));
			dv1_q <= sat32(33'(t_q[1][1]) - 33'(t_q[0][1]));
			du2_q <= sat32(33'(t_q[2][0]) - 33'(t_q[0][0]));
			dv2_q <= sat32(33'(t_q[2][1]) - 33'(t_q[0][1]));
		end
		if (state_q == S_MUL) begin
			if (!step_q[0]) acc_q <= mprod;
			else begin
				// odd step: difference of pair
				if (step_q == 4'd1) begin
					dneg_q  <= (acc_q - mprod) < 0;
					dm_q    <= NUM_W'(((acc_q - mprod) < 0) ? (mprod - acc_q) : (acc_q - mprod));
					degen_q <= (acc_q == mprod);
				end else begin
					nneg_q[step_q[3:1] - 3'd1] <= (acc_q - mprod) < 0;
					num_q[step_q[3:1] - 3'd1]  <= NUM_W'(((acc_q - mprod) < 0)
						? (mprod - acc_q) : (acc_q - mprod));
				end
			end
		end
		if (state_q == S_DIVS && degen_q)
			for (int k = 0; k < 6; k++) vec_q[k] <= '0;
		if (state_q == S_DIVW && drsp.done)
			vec_q[step_q[2:0] > 3'd5 ? 3'd0 : step_q[2:0]] <= drsp.quo;
		if (state_q == S_CRS) begin
			prod_q <= mprod;
			if (step_q[0]) acc_q <= prod_q;
			else if (step_q != 4'd0)
				c_q[step_q[2:1] - 2'd1] <= 50'(acc_q - prod_q);
			dot_q <= '0;
		end
		if (state_q == S_DOT) begin
			if (step_q[0])
				dot_q <= dot_q + (84'(mprod) <<< 25);
			else
				dot_q <= dot_q + 84'(mprod);
		end
		if (state_q == S_OUT) begin
			tangent_x <= tsel[0]; tangent_y <= tsel[1]; tangent_z <= tsel[2];
			bitangent_x <= vec_q[3]; bitangent_y <= vec_q[4]; bitangent_z <= vec_q[5];
			degenerate <= degen_q;
			last_of_triangle <= (vtx_q == 2'd2);
		end
	end

endmodule
